@@ rtl/gf2nfa_pkg.sv @@
// Shared types and constants for the GF(2^n) arithmetic unit.
// Used by the controller, the datapath and the top level.
package gf2nfa_pkg;

   localparam int MAX_DEGREE = 32;
   localparam int ELEM_W     = MAX_DEGREE;
   localparam int POLY_W     = MAX_DEGREE + 1;
   localparam int DEG_W      = 6;
   localparam int CNT_W      = 5;

   localparam logic [1:0] FUNC_ADD = 2'd0;
   localparam logic [1:0] FUNC_MUL = 2'd1;
   localparam logic [1:0] FUNC_INV = 2'd2;

   localparam logic CSR_DEGREE = 1'b0;
   localparam logic CSR_POLY   = 1'b1;

   localparam logic [DEG_W-1:0]  DEGREE_RESET = 6'd8;
   localparam logic [POLY_W-1:0] POLY_RESET   = 33'd283;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_INV,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic load;
      logic mul_step;
      logic inv_step;
      logic capture;
   } cmd_type;

   typedef struct packed {
      logic mul_last;
      logic inv_done;
   } status_type;

endpackage

@@ rtl/gf2nfa_ctrl.sv @@
// Controller state machine for the GF(2^n) arithmetic unit.
// Sequences load, multiply and inverse steps and the output register handshake.
// Depends on gf2nfa_pkg.
module gf2nfa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_func,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output gf2nfa_pkg::cmd_type    cmd,
   input  gf2nfa_pkg::status_type status
);

   gf2nfa_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gf2nfa_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      req_stall    = 1'b1;
      case (state_ff)
         gf2nfa_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               case (req_func)
                  gf2nfa_pkg::FUNC_MUL: state_in = gf2nfa_pkg::ST_MUL;
                  gf2nfa_pkg::FUNC_INV: state_in = gf2nfa_pkg::ST_INV;
                  default:              state_in = gf2nfa_pkg::ST_FIN;
               endcase
            end
         end
         gf2nfa_pkg::ST_MUL: begin
            cmd.mul_step = 1'b1;
            if (status.mul_last) begin
               state_in = gf2nfa_pkg::ST_FIN;
            end
         end
         gf2nfa_pkg::ST_INV: begin
            if (status.inv_done) begin
               state_in = gf2nfa_pkg::ST_FIN;
            end else begin
               cmd.inv_step = 1'b1;
            end
         end
         gf2nfa_pkg::ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.capture  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = gf2nfa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gf2nfa_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/gf2nfa_dpath.sv @@
// Datapath for the GF(2^n) arithmetic unit: configuration registers, operand
// registers, shift-and-XOR multiplier, Euclid inverse and output register.
// Depends on gf2nfa_pkg.
module gf2nfa_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic [gf2nfa_pkg::POLY_W-1:0]       csr_wdata,
   input  logic [1:0]                          req_func,
   input  logic [gf2nfa_pkg::ELEM_W-1:0]       req_operand_a,
   input  logic [gf2nfa_pkg::ELEM_W-1:0]       req_operand_b,
   output logic [gf2nfa_pkg::ELEM_W-1:0]       rsp_result,
   input  gf2nfa_pkg::cmd_type                 cmd,
   output gf2nfa_pkg::status_type              status
);

   logic [gf2nfa_pkg::DEG_W-1:0]  cfg_degree_ff;
   logic [gf2nfa_pkg::POLY_W-1:0] cfg_poly_ff;

   logic [1:0]                    func_ff;
   logic [gf2nfa_pkg::ELEM_W-1:0] a_ff, b_ff, acc_ff, acc_in;
   logic [gf2nfa_pkg::CNT_W-1:0]  cnt_ff;
   logic [gf2nfa_pkg::POLY_W-1:0] r0_ff, r1_ff, r0_in, r1_in;
   logic [gf2nfa_pkg::ELEM_W-1:0] t0_ff, t1_ff, t0_in, t1_in;
   logic [gf2nfa_pkg::DEG_W-1:0]  d0_ff, d1_ff, d0_in, d1_in;
   logic [gf2nfa_pkg::ELEM_W-1:0] result_ff, result_in;

   logic [gf2nfa_pkg::DEG_W-1:0]  n_eff, n_minus1, shamt;
   logic [gf2nfa_pkg::POLY_W-1:0] mask_wide, modulus, mul_shift;
   logic [gf2nfa_pkg::ELEM_W-1:0] mask;
   logic                          r0_zero, r0_top, r1_top;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_degree_ff <= gf2nfa_pkg::DEGREE_RESET;
         cfg_poly_ff   <= gf2nfa_pkg::POLY_RESET;
      end else if (csr_we) begin
         case (csr_index)
            gf2nfa_pkg::CSR_DEGREE: cfg_degree_ff <= csr_wdata[gf2nfa_pkg::DEG_W-1:0];
            gf2nfa_pkg::CSR_POLY:   cfg_poly_ff   <= csr_wdata;
            default:                cfg_poly_ff   <= cfg_poly_ff;
         endcase
      end
   end

   always_comb begin
      if (cfg_degree_ff < 6'd2) begin
         n_eff = 6'd2;
      end else if (cfg_degree_ff > 6'(gf2nfa_pkg::MAX_DEGREE)) begin
         n_eff = 6'(gf2nfa_pkg::MAX_DEGREE);
      end else begin
         n_eff = cfg_degree_ff;
      end
      n_minus1  = n_eff - 6'd1;
      mask_wide = (33'd1 << n_eff) - 33'd1;
      mask      = mask_wide[gf2nfa_pkg::ELEM_W-1:0];
      modulus   = (33'd1 << n_eff) | (cfg_poly_ff & mask_wide);
   end

   // multiply: MSB-first interleaved product and reduction
   always_comb begin
      mul_shift = {acc_ff, 1'b0};
      if (mul_shift[n_eff]) begin
         mul_shift = mul_shift ^ modulus;
      end
      acc_in = mul_shift[gf2nfa_pkg::ELEM_W-1:0] ^ (b_ff[cnt_ff] ? a_ff : '0);
   end

   // inverse: one Euclid action per cycle with tracked degrees
   always_comb begin
      r0_zero = (r0_ff == '0);
      r0_top  = r0_ff[d0_ff];
      r1_top  = r1_ff[d1_ff];
      shamt   = d0_ff - d1_ff;
      r0_in   = r0_ff;
      r1_in   = r1_ff;
      t0_in   = t0_ff;
      t1_in   = t1_ff;
      d0_in   = d0_ff;
      d1_in   = d1_ff;
      if (r0_zero || (r0_top && r1_top && (d0_ff < d1_ff))) begin
         r0_in = r1_ff;
         r1_in = r0_ff;
         t0_in = t1_ff;
         t1_in = t0_ff;
         d0_in = d1_ff;
         d1_in = d0_ff;
      end else if (!r0_top) begin
         d0_in = d0_ff - 6'd1;
      end else if (!r1_top) begin
         d1_in = d1_ff - 6'd1;
      end else begin
         r0_in = r0_ff ^ (r1_ff << shamt);
         t0_in = t0_ff ^ (t1_ff << shamt);
      end
   end

   always_comb begin
      case (func_ff)
         gf2nfa_pkg::FUNC_ADD: result_in = a_ff ^ b_ff;
         gf2nfa_pkg::FUNC_MUL: result_in = acc_ff;
         gf2nfa_pkg::FUNC_INV: result_in = t0_ff & mask;
         default:              result_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_func;
         a_ff    <= req_operand_a & mask;
         b_ff    <= req_operand_b & mask;
         acc_ff  <= '0;
         cnt_ff  <= n_minus1[gf2nfa_pkg::CNT_W-1:0];
         r0_ff   <= modulus;
         r1_ff   <= {1'b0, req_operand_a & mask};
         t0_ff   <= '0;
         t1_ff   <= 32'd1;
         d0_ff   <= n_eff;
         d1_ff   <= 6'(gf2nfa_pkg::ELEM_W - 1);
      end else if (cmd.mul_step) begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_ff - 5'd1;
      end else if (cmd.inv_step) begin
         r0_ff <= r0_in;
         r1_ff <= r1_in;
         t0_ff <= t0_in;
         t1_ff <= t1_in;
         d0_ff <= d0_in;
         d1_ff <= d1_in;
      end
      if (cmd.capture) begin
         result_ff <= result_in;
      end
   end

   assign status.mul_last = (cnt_ff == '0);
   assign status.inv_done = (r1_ff == '0);
   assign rsp_result      = result_ff;

endmodule

@@ rtl/gf2n_field_arithmetic_top.sv @@
// GF(2^n) arithmetic unit in polynomial basis: add, multiply, inverse.
// Request channel: req_valid/req_stall with req_func, req_operand_a and
// req_operand_b; an item is taken when req_valid is high and req_stall low.
// Response channel: rsp_valid/rsp_stall with rsp_result, one result per item.
// Configuration: csr_we writes csr_wdata to register csr_index
// (0 field degree n, 1 reduction polynomial); write only while idle.
// One item is in work at a time. From acceptance to rsp_valid: add and the
// unused code go straight to the result capture, multiply takes one shift-XOR
// step of the multiplier per bit of operand_b, inverse takes one Euclid
// action per cycle (degree step, swap or aligned XOR; the degree search of
// operand_a starts at bit 31). The next item is taken at the earliest in the
// cycle its predecessor's result turns valid.
// A finished result sits in the output register, so the next item is taken
// while the receiver stalls; if a second result finishes before the first is
// taken, the unit holds it and stalls the request channel.
// Synchronous reset returns to idle with no result pending, field degree 8
// and polynomial x^8+x^4+x^3+x+1.
// Depends on gf2nfa_pkg, gf2nfa_ctrl and gf2nfa_dpath.
module gf2n_field_arithmetic_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [gf2nfa_pkg::POLY_W-1:0] csr_wdata,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_func,
   input  logic [gf2nfa_pkg::ELEM_W-1:0] req_operand_a,
   input  logic [gf2nfa_pkg::ELEM_W-1:0] req_operand_b,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [gf2nfa_pkg::ELEM_W-1:0] rsp_result
);

   gf2nfa_pkg::cmd_type    cmd;
   gf2nfa_pkg::status_type status;

   gf2nfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_func  (req_func),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   gf2nfa_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_func      (req_func),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .rsp_result    (rsp_result),
      .cmd           (cmd),
      .status        (status)
   );

endmodule
